// ===== rtl/swm_pkg.sv =====
// swm_pkg: shared types and constants for the sliding window minimum block.
// No dependencies; used by swm_cell and sliding_window_minimum.
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;
  localparam int CFG_BYTES_W = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic shift;   // a word is accepted this cycle
    logic clear;   // accepted word starts a new sequence
    logic cfg_we;  // window length is written this cycle
  } cell_ctrl_t;

endpackage

// ===== rtl/sliding_window_minimum.sv =====
// sliding_window_minimum: top level, a chain of prefix-minimum cells.
// Depends on swm_pkg and swm_cell.
// A result word appears on out_* the cycle after its sample is taken.
// Throughput: one sample per cycle unless out_tready stalls; cells update in parallel.
// Reset (rst_n, synchronous, active low): window length 1, fill count zero,
//   output empty; cell contents are not cleared and are never read unfilled.
module sliding_window_minimum #(
  parameter int MAX_WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic [0:0]  in_tuser,   // [0] new_sequence
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] window_min
  // window length write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [6:0] window_length
);

  // Cell i holds the minimum of the last i+1 samples of the sequence.
  // A window of L samples is then min(new sample, cell L-2), so only
  // MAX_WINDOW-1 cells are needed.
  localparam int NCELL = MAX_WINDOW - 1;
  localparam int LW    = $clog2(MAX_WINDOW + 1);

  swm_pkg::cell_ctrl_t ctrl;
  swm_pkg::sample_t    sample;
  swm_pkg::sample_t    cell_min [NCELL];
  swm_pkg::sample_t    tap_word [NCELL];
  logic [NCELL-1:0]    tap_nxt;

  logic [LW-1:0]       len_r, len_nxt;
  logic [LW-1:0]       fill_r, fill_nxt;
  logic                out_valid_r;
  swm_pkg::sample_t    out_data_r;
  swm_pkg::sample_t    tap_sel;
  swm_pkg::sample_t    result;
  logic                in_acc;
  logic                produce;
  logic [31:0]         cfg_len32;

  assign sample    = swm_pkg::sample_t'(in_tdata[swm_pkg::SAMPLE_W-1:0]);
  // output register: a new sample may enter when no result is held or the held result leaves
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign ctrl.shift  = in_acc;
  assign ctrl.clear  = in_tuser[0];
  assign ctrl.cfg_we = cfg_valid && cfg_ready;

  // window length clamped to 1..MAX_WINDOW when written
  assign cfg_len32 = 32'(cfg_data[swm_pkg::CFG_W-1:0]);
  always_comb begin
    if (cfg_len32 == 32'd0) begin
      len_nxt = LW'(1);
    end else if (cfg_len32 > 32'(MAX_WINDOW)) begin
      len_nxt = LW'(MAX_WINDOW);
    end else begin
      len_nxt = LW'(cfg_len32);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LW'(1);
    end else if (ctrl.cfg_we) begin
      len_r <= len_nxt;
    end
  end

  // cell chain; cell 0 takes the sample itself as its neighbor
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    assign tap_nxt[i] = (len_nxt == LW'(i + 2));
    swm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .sample   (sample),
      .prev_min ((i == 0) ? sample : cell_min[(i == 0) ? 0 : i - 1]),
      .tap_nxt  (tap_nxt[i]),
      .min_r    (cell_min[i]),
      .tap_word (tap_word[i])
    );
  end

  // at most one cell is tapped: OR of the gated words picks it
  always_comb begin
    tap_sel = '0;
    for (int i = 0; i < NCELL; i++) begin
      tap_sel = tap_sel | tap_word[i];
    end
  end

  always_comb begin
    if ((len_r == LW'(1)) || (sample < tap_sel)) begin
      result = sample;
    end else begin
      result = tap_sel;
    end
  end

  // fill count of the current sequence, saturating at MAX_WINDOW
  always_comb begin
    if (ctrl.clear) begin
      fill_nxt = LW'(1);
    end else if (fill_r < LW'(MAX_WINDOW)) begin
      fill_nxt = fill_r + LW'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  assign produce = (fill_nxt >= len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_acc) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= produce;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && produce) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 32'(out_data_r);

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LW'(MAX_WINDOW))
    else $error("fill count beyond window store");

  a_new_seq_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0]) |=> (fill_r == LW'(1)))
    else $error("new sequence did not restart fill count");

  a_len1_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (len_r == LW'(1))) |=> (out_tvalid && (out_tdata == $past(in_tdata))))
    else $error("window of one must echo the sample");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_acc))
    else $error("result word without an accepted sample");
`endif

endmodule

// ===== rtl/swm_cell.sv =====
// swm_cell: one stage of the prefix-minimum chain plus its output tap bit.
// Depends on swm_pkg.
module swm_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swm_pkg::cell_ctrl_t  ctrl,
  input  swm_pkg::sample_t     sample,    // accepted sample
  input  swm_pkg::sample_t     prev_min,  // neighbor's held minimum
  input  logic                 tap_nxt,   // this cell is the window tap
  output swm_pkg::sample_t     min_r,     // min of the last (index+1) samples
  output swm_pkg::sample_t     tap_word   // min_r when tapped, else zero
);

  swm_pkg::sample_t min_nxt;
  logic             tap_r;

  // new sequence drops older samples; otherwise extend neighbor's range by one
  always_comb begin
    if (ctrl.clear || (sample < prev_min)) begin
      min_nxt = sample;
    end else begin
      min_nxt = prev_min;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      min_r <= min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= 1'b0;
    end else if (ctrl.cfg_we) begin
      tap_r <= tap_nxt;
    end
  end

  assign tap_word = tap_r ? min_r : '0;

endmodule
